@@ rtl/core/segx_pkg.sv @@
// segx_pkg: shared constants and types for the segment intersection block
// no dependencies; compiled first
package segx_pkg;

  parameter int unsigned COORD_WIDTH_DEF = 16;
  parameter int unsigned THRESH_WIDTH    = 16;

  // 0.001 in the Q16.16 units of the cross-product denominator
  parameter logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd66;

  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } segx_ctl_t;

endpackage

@@ rtl/core/segx_if.sv @@
// segx_pair_if and segx_res_if: valid/ready channels for segment pairs and results
// depends on segx_pkg for the default coordinate width
interface segx_pair_if #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a0_x;
  logic signed [COORD_WIDTH-1:0] a0_y;
  logic signed [COORD_WIDTH-1:0] a1_x;
  logic signed [COORD_WIDTH-1:0] a1_y;
  logic signed [COORD_WIDTH-1:0] b0_x;
  logic signed [COORD_WIDTH-1:0] b0_y;
  logic signed [COORD_WIDTH-1:0] b1_x;
  logic signed [COORD_WIDTH-1:0] b1_y;

  modport source (
    output valid, a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y,
    input  ready
  );
  modport sink (
    input  valid, a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y,
    output ready
  );
endinterface

interface segx_res_if #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] hit_x;
  logic signed [COORD_WIDTH-1:0] hit_y;

  modport source (
    output valid, hit, hit_x, hit_y,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_x, hit_y,
    output ready
  );
endinterface

@@ rtl/core/segx_front.sv @@
// segx_front: six-stage front end - differences, cross products, sign fix-up,
// range tests and the dividend products for the hit point; uses segx_pkg
module segx_front #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  in_valid_i,
  input  logic signed [COORD_WIDTH-1:0]         a0_x_i,
  input  logic signed [COORD_WIDTH-1:0]         a0_y_i,
  input  logic signed [COORD_WIDTH-1:0]         a1_x_i,
  input  logic signed [COORD_WIDTH-1:0]         a1_y_i,
  input  logic signed [COORD_WIDTH-1:0]         b0_x_i,
  input  logic signed [COORD_WIDTH-1:0]         b0_y_i,
  input  logic signed [COORD_WIDTH-1:0]         b1_x_i,
  input  logic signed [COORD_WIDTH-1:0]         b1_y_i,
  input  logic [segx_pkg::THRESH_WIDTH-1:0]     thresh_i,
  output logic                                  out_valid_o,
  output segx_pkg::segx_ctl_t                   out_ctl_o,
  output logic signed [COORD_WIDTH-1:0]         out_a0_x_o,
  output logic signed [COORD_WIDTH-1:0]         out_a0_y_o,
  output logic [3*COORD_WIDTH+1:0]              out_num_x_o,
  output logic [3*COORD_WIDTH+1:0]              out_num_y_o,
  output logic [2*COORD_WIDTH+1:0]              out_den_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned PW = 2 * W + 2;  // one cross product
  localparam int unsigned FW = 2 * W + 3;  // difference of two products
  localparam int unsigned TW = 2 * W + 2;  // divisor after sign removal
  localparam int unsigned NW = 3 * W + 2;  // dividend
  localparam int unsigned HW = W + 1;      // half of the numerator split

  // stage 1: edge vectors and offset
  logic                 v1_q;
  logic signed [W:0]    s1x_q, s1y_q, s2x_q, s2y_q, dx_q, dy_q;
  logic signed [W-1:0]  a0x1_q, a0y1_q;
  // stage 2: cross products
  logic                 v2_q;
  logic signed [PW-1:0] pf0_q, pf1_q, ps0_q, ps1_q, pt0_q, pt1_q;
  logic signed [W:0]    s1x2_q, s1y2_q;
  logic signed [W-1:0]  a0x2_q, a0y2_q;
  // stage 3: denominator and numerators
  logic                 v3_q;
  logic signed [FW-1:0] f3_q, sn3_q, tn3_q;
  logic signed [W:0]    s1x3_q, s1y3_q;
  logic signed [W-1:0]  a0x3_q, a0y3_q;
  // stage 4: denominator made positive
  logic                 v4_q;
  logic [FW-1:0]        fa4_q, sna4_q, tna4_q;
  logic [W-1:0]         magx4_q, magy4_q;
  logic                 negx4_q, negy4_q;
  logic signed [W-1:0]  a0x4_q, a0y4_q;
  // stage 5: hit decision and partial products
  logic                 v5_q;
  segx_pkg::segx_ctl_t  ctl5_q;
  logic [TW-1:0]        den5_q;
  logic [2*W:0]         pxl5_q, pxh5_q, pyl5_q, pyh5_q;
  logic signed [W-1:0]  a0x5_q, a0y5_q;
  // stage 6: dividends
  logic                 v6_q;
  segx_pkg::segx_ctl_t  ctl6_q;
  logic [TW-1:0]        den6_q;
  logic [NW-1:0]        nx6_q, ny6_q;
  logic signed [W-1:0]  a0x6_q, a0y6_q;

  logic                 neg_f;
  logic [FW-1:0]        fa_d, sna_d, tna_d;
  logic [W:0]           absx, absy;
  logic                 sn_ok, tn_ok, big_ok;
  segx_pkg::segx_ctl_t  ctl5_d;

  always_comb begin
    neg_f = f3_q[FW-1];
    fa_d  = neg_f ? -f3_q  : f3_q;
    sna_d = neg_f ? -sn3_q : sn3_q;
    tna_d = neg_f ? -tn3_q : tn3_q;
    absx  = s1x3_q[W] ? -s1x3_q : s1x3_q;
    absy  = s1y3_q[W] ? -s1y3_q : s1y3_q;
  end

  always_comb begin
    // both parameters in [0,1] once the denominator is positive
    sn_ok        = !sna4_q[FW-1] && (sna4_q <= fa4_q);
    tn_ok        = !tna4_q[FW-1] && (tna4_q <= fa4_q);
    big_ok       = (|fa4_q) && (fa4_q >= FW'(thresh_i));
    ctl5_d.hit   = big_ok && sn_ok && tn_ok;
    ctl5_d.neg_x = negx4_q;
    ctl5_d.neg_y = negy4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1x_q  <= {a1_x_i[W-1], a1_x_i} - {a0_x_i[W-1], a0_x_i};
      s1y_q  <= {a1_y_i[W-1], a1_y_i} - {a0_y_i[W-1], a0_y_i};
      s2x_q  <= {b1_x_i[W-1], b1_x_i} - {b0_x_i[W-1], b0_x_i};
      s2y_q  <= {b1_y_i[W-1], b1_y_i} - {b0_y_i[W-1], b0_y_i};
      dx_q   <= {a0_x_i[W-1], a0_x_i} - {b0_x_i[W-1], b0_x_i};
      dy_q   <= {a0_y_i[W-1], a0_y_i} - {b0_y_i[W-1], b0_y_i};
      a0x1_q <= a0_x_i;
      a0y1_q <= a0_y_i;

      pf0_q  <= s1x_q * s2y_q;
      pf1_q  <= s2x_q * s1y_q;
      ps0_q  <= s1x_q * dy_q;
      ps1_q  <= s1y_q * dx_q;
      pt0_q  <= s2x_q * dy_q;
      pt1_q  <= s2y_q * dx_q;
      s1x2_q <= s1x_q;
      s1y2_q <= s1y_q;
      a0x2_q <= a0x1_q;
      a0y2_q <= a0y1_q;

      f3_q   <= {pf0_q[PW-1], pf0_q} - {pf1_q[PW-1], pf1_q};
      sn3_q  <= {ps0_q[PW-1], ps0_q} - {ps1_q[PW-1], ps1_q};
      tn3_q  <= {pt0_q[PW-1], pt0_q} - {pt1_q[PW-1], pt1_q};
      s1x3_q <= s1x2_q;
      s1y3_q <= s1y2_q;
      a0x3_q <= a0x2_q;
      a0y3_q <= a0y2_q;

      fa4_q   <= fa_d;
      sna4_q  <= sna_d;
      tna4_q  <= tna_d;
      magx4_q <= absx[W-1:0];
      magy4_q <= absy[W-1:0];
      negx4_q <= s1x3_q[W];
      negy4_q <= s1y3_q[W];
      a0x4_q  <= a0x3_q;
      a0y4_q  <= a0y3_q;

      // tn split in halves so each multiplier stays near word width
      ctl5_q <= ctl5_d;
      den5_q <= fa4_q[TW-1:0];
      pxl5_q <= tna4_q[HW-1:0] * magx4_q;
      pxh5_q <= tna4_q[TW-1:HW] * magx4_q;
      pyl5_q <= tna4_q[HW-1:0] * magy4_q;
      pyh5_q <= tna4_q[TW-1:HW] * magy4_q;
      a0x5_q <= a0x4_q;
      a0y5_q <= a0y4_q;

      ctl6_q <= ctl5_q;
      den6_q <= den5_q;
      nx6_q  <= NW'(pxl5_q) + {pxh5_q, {HW{1'b0}}};
      ny6_q  <= NW'(pyl5_q) + {pyh5_q, {HW{1'b0}}};
      a0x6_q <= a0x5_q;
      a0y6_q <= a0y5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign out_ctl_o   = ctl6_q;
  assign out_a0_x_o  = a0x6_q;
  assign out_a0_y_o  = a0y6_q;
  assign out_num_x_o = nx6_q;
  assign out_num_y_o = ny6_q;
  assign out_den_o   = den6_q;

endmodule

@@ rtl/core/segx_div.sv @@
// segx_div: pipelined restoring divider, one quotient bit per stage, x and y
// lanes side by side; uses segx_pkg for the control struct
module segx_div #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  segx_pkg::segx_ctl_t           in_ctl_i,
  input  logic signed [COORD_WIDTH-1:0] in_a0_x_i,
  input  logic signed [COORD_WIDTH-1:0] in_a0_y_i,
  input  logic [3*COORD_WIDTH+1:0]      in_num_x_i,
  input  logic [3*COORD_WIDTH+1:0]      in_num_y_i,
  input  logic [2*COORD_WIDTH+1:0]      in_den_i,
  output logic                          out_valid_o,
  output segx_pkg::segx_ctl_t           out_ctl_o,
  output logic signed [COORD_WIDTH-1:0] out_a0_x_o,
  output logic signed [COORD_WIDTH-1:0] out_a0_y_o,
  output logic [COORD_WIDTH-1:0]        out_quo_x_o,
  output logic [COORD_WIDTH-1:0]        out_quo_y_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned TW = 2 * W + 2;
  localparam int unsigned NW = 3 * W + 2;

  // dividend bits still to come shift out at the top, quotient bits in at the bottom
  function automatic logic [TW+W-1:0] div_step(input logic [TW-1:0] rem,
                                               input logic [W-1:0]  bits,
                                               input logic [TW-1:0] den);
    logic [TW:0] trial;
    logic [TW:0] diff;
    logic        ge;
    trial = {rem, bits[W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
    return ge ? {diff[TW-1:0], bits[W-2:0], 1'b1} : {trial[TW-1:0], bits[W-2:0], 1'b0};
  endfunction

  logic                v_q    [W];
  segx_pkg::segx_ctl_t ctl_q  [W];
  logic signed [W-1:0] a0x_q  [W];
  logic signed [W-1:0] a0y_q  [W];
  logic [TW-1:0]       den_q  [W];
  logic [TW-1:0]       remx_q [W];
  logic [TW-1:0]       remy_q [W];
  logic [W-1:0]        bitx_q [W];
  logic [W-1:0]        bity_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic                v_in;
    segx_pkg::segx_ctl_t ctl_in;
    logic signed [W-1:0] a0x_in, a0y_in;
    logic [TW-1:0]       den_in, remx_in, remy_in;
    logic [W-1:0]        bitx_in, bity_in;
    logic [TW+W-1:0]     stepx, stepy;

    if (k == 0) begin : g_head
      always_comb begin
        v_in    = in_valid_i;
        ctl_in  = in_ctl_i;
        a0x_in  = in_a0_x_i;
        a0y_in  = in_a0_y_i;
        den_in  = in_den_i;
        remx_in = in_num_x_i[NW-1:W];
        remy_in = in_num_y_i[NW-1:W];
        bitx_in = in_num_x_i[W-1:0];
        bity_in = in_num_y_i[W-1:0];
      end
    end else begin : g_link
      always_comb begin
        v_in    = v_q[k-1];
        ctl_in  = ctl_q[k-1];
        a0x_in  = a0x_q[k-1];
        a0y_in  = a0y_q[k-1];
        den_in  = den_q[k-1];
        remx_in = remx_q[k-1];
        remy_in = remy_q[k-1];
        bitx_in = bitx_q[k-1];
        bity_in = bity_q[k-1];
      end
    end

    assign stepx = div_step(remx_in, bitx_in, den_in);
    assign stepy = div_step(remy_in, bity_in, den_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[k]  <= ctl_in;
        a0x_q[k]  <= a0x_in;
        a0y_q[k]  <= a0y_in;
        den_q[k]  <= den_in;
        remx_q[k] <= stepx[TW+W-1:W];
        remy_q[k] <= stepy[TW+W-1:W];
        bitx_q[k] <= stepx[W-1:0];
        bity_q[k] <= stepy[W-1:0];
      end
    end
  end

  assign out_valid_o = v_q[W-1];
  assign out_ctl_o   = ctl_q[W-1];
  assign out_a0_x_o  = a0x_q[W-1];
  assign out_a0_y_o  = a0y_q[W-1];
  assign out_quo_x_o = bitx_q[W-1];
  assign out_quo_y_o = bity_q[W-1];

endmodule

@@ rtl/core/segment_intersection.sv @@
// segment_intersection: top level - threshold register, front end, divider,
// hit point assembly and a two-word output skid; uses segx_pkg, segx_if, segx_front, segx_div
//
//   channel     dir  handshake         payload
//   pair_i      in   valid/ready       a0_x a0_y a1_x a1_y b0_x b0_y b1_x b1_y
//   res_o       out  valid/ready       hit hit_x hit_y
//   cfg_*_i     in   write enable      parallel_threshold (16 bits)
//
// one word accepted per cycle while the skid has a free slot; a result is offered once its
// pair has gone through the pipeline (the accepting edge loads the first front stage, then five more front
// stages, one divider stage per quotient bit and the skid slot follow)
// the pipeline advances as a whole while the skid has a free slot; the skid holds
// two words, so pair_i.ready drops only after two results are left waiting
// reset clears the valid bits and the skid; the threshold returns to 66
module segment_intersection #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [segx_pkg::THRESH_WIDTH-1:0] cfg_wdata_i,
  segx_pair_if.sink                         pair_i,
  segx_res_if.source                        res_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned TW = 2 * W + 2;
  localparam int unsigned NW = 3 * W + 2;
  localparam logic [1:0] SkidFull = 2'd2;

  logic [segx_pkg::THRESH_WIDTH-1:0] thresh_q;

  logic                en;
  logic                fe_valid;
  segx_pkg::segx_ctl_t fe_ctl;
  logic signed [W-1:0] fe_a0x, fe_a0y;
  logic [NW-1:0]       fe_numx, fe_numy;
  logic [TW-1:0]       fe_den;

  logic                dv_valid;
  segx_pkg::segx_ctl_t dv_ctl;
  logic signed [W-1:0] dv_a0x, dv_a0y;
  logic [W-1:0]        dv_qx, dv_qy;

  logic [W-1:0]        offx, offy;
  logic signed [W-1:0] ptx, pty;

  logic                sk_hit_q [2];
  logic signed [W-1:0] sk_x_q   [2];
  logic signed [W-1:0] sk_y_q   [2];
  logic                wr_q, rd_q;
  logic [1:0]          cnt_q, cnt_d;
  logic                push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= segx_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign en           = (cnt_q != SkidFull);
  assign pair_i.ready = en;

  segx_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (pair_i.valid),
    .a0_x_i      (pair_i.a0_x),
    .a0_y_i      (pair_i.a0_y),
    .a1_x_i      (pair_i.a1_x),
    .a1_y_i      (pair_i.a1_y),
    .b0_x_i      (pair_i.b0_x),
    .b0_y_i      (pair_i.b0_y),
    .b1_x_i      (pair_i.b1_x),
    .b1_y_i      (pair_i.b1_y),
    .thresh_i    (thresh_q),
    .out_valid_o (fe_valid),
    .out_ctl_o   (fe_ctl),
    .out_a0_x_o  (fe_a0x),
    .out_a0_y_o  (fe_a0y),
    .out_num_x_o (fe_numx),
    .out_num_y_o (fe_numy),
    .out_den_o   (fe_den)
  );

  segx_div #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (fe_valid),
    .in_ctl_i    (fe_ctl),
    .in_a0_x_i   (fe_a0x),
    .in_a0_y_i   (fe_a0y),
    .in_num_x_i  (fe_numx),
    .in_num_y_i  (fe_numy),
    .in_den_i    (fe_den),
    .out_valid_o (dv_valid),
    .out_ctl_o   (dv_ctl),
    .out_a0_x_o  (dv_a0x),
    .out_a0_y_o  (dv_a0y),
    .out_quo_x_o (dv_qx),
    .out_quo_y_o (dv_qy)
  );

  // quotient carries the sign of the edge vector; the point always fits
  always_comb begin
    offx = dv_ctl.neg_x ? -dv_qx : dv_qx;
    offy = dv_ctl.neg_y ? -dv_qy : dv_qy;
    ptx  = dv_ctl.hit ? (dv_a0x + offx) : '0;
    pty  = dv_ctl.hit ? (dv_a0y + offy) : '0;
  end

  assign push = en && dv_valid;
  assign pop  = res_o.valid && res_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      sk_hit_q[wr_q] <= dv_ctl.hit;
      sk_x_q[wr_q]   <= ptx;
      sk_y_q[wr_q]   <= pty;
    end
  end

  assign res_o.valid = (cnt_q != 2'd0);
  assign res_o.hit   = sk_hit_q[rd_q];
  assign res_o.hit_x = sk_x_q[rd_q];
  assign res_o.hit_y = sk_y_q[rd_q];

`ifndef NO_ASSERTIONS
  // a miss always carries a zero point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit |-> (res_o.hit_x == '0) && (res_o.hit_y == '0))
    else $error("miss word with nonzero point");

  // simultaneous push and pop leaves the skid level unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && pop |=> $stable(cnt_q))
    else $error("skid level moved on push with pop");

  // a lone push raises the level by one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("skid level wrong after push");

  // a full skid stays full until a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == SkidFull) && !pop |=> cnt_q == SkidFull)
    else $error("full skid changed without a pop");
`endif

endmodule

@@ tb/sv/segment_intersection_tb.sv @@
`timescale 1ns / 1ps
// segment_intersection_tb: self-checking bench for the segment intersection block
// drives segment pairs, checks hit flag and point against a local predictor
// depends on segx_pkg, segx_if and the segment_intersection rtl
module segment_intersection_tb;

  localparam int unsigned CW    = segx_pkg::COORD_WIDTH_DEF;
  localparam int unsigned TH_W  = segx_pkg::THRESH_WIDTH;
  localparam int          LAT   = CW + 6;
  localparam int          LIMIT = 200000;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;

  typedef struct packed {
    coord_t a0_x, a0_y, a1_x, a1_y;
    coord_t b0_x, b0_y, b1_x, b1_y;
  } pair_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_x;
    coord_t hit_y;
  } crossing_t;

  typedef struct {
    pair_t     p;
    bit        typed;
    crossing_t want;
  } pair_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TH_W-1:0] cfg_wdata_i;

  segx_pair_if #(.COORD_WIDTH(CW)) pair_ch ();
  segx_res_if  #(.COORD_WIDTH(CW)) res_ch ();

  segment_intersection #(.COORD_WIDTH(CW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pair_i      (pair_ch),
    .res_o       (res_ch)
  );

  crossing_t             crossing_q[$];
  pair_row_t             pair_rows[$];
  logic [TH_W-1:0]       thresh_model;
  int                    crossing_errs;
  int                    pairs_sent;
  int                    rx_stall;
  bit                    rx_hold;
  bit                    steady;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic crossing_t predict_crossing(input pair_t p,
                                                 input logic [TH_W-1:0] thr);
    wide_t s1x, s1y, s2x, s2y, dx, dy, den, sn, tn;
    crossing_t r;
    r   = '0;
    s1x = wide_t'(p.a1_x) - wide_t'(p.a0_x);
    s1y = wide_t'(p.a1_y) - wide_t'(p.a0_y);
    s2x = wide_t'(p.b1_x) - wide_t'(p.b0_x);
    s2y = wide_t'(p.b1_y) - wide_t'(p.b0_y);
    dx  = wide_t'(p.a0_x) - wide_t'(p.b0_x);
    dy  = wide_t'(p.a0_y) - wide_t'(p.b0_y);
    den = s1x * s2y - s2x * s1y;
    sn  = s1x * dy - s1y * dx;
    tn  = s2x * dy - s2y * dx;
    // fold the sign into the numerators so the range test needs no division
    if (den < 0) begin
      den = -den;
      sn  = -sn;
      tn  = -tn;
    end
    if (den == 0 || den < wide_t'(thr)) return r;
    if (sn < 0 || tn < 0 || sn > den || tn > den) return r;
    r.hit   = 1'b1;
    r.hit_x = coord_t'(wide_t'(p.a0_x) + (tn * s1x) / den);
    r.hit_y = coord_t'(wide_t'(p.a0_y) + (tn * s1y) / den);
    return r;
  endfunction

  function automatic pair_t mk_pair(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    pair_t p;
    p.a0_x = coord_t'(ax0); p.a0_y = coord_t'(ay0);
    p.a1_x = coord_t'(ax1); p.a1_y = coord_t'(ay1);
    p.b0_x = coord_t'(bx0); p.b0_y = coord_t'(by0);
    p.b1_x = coord_t'(bx1); p.b1_y = coord_t'(by1);
    return p;
  endfunction

  function automatic pair_row_t row(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1,
                                    input bit typed, input bit hit, input int hx, hy);
    pair_row_t r;
    r.p     = mk_pair(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    r.typed = typed;
    r.want  = '{hit, coord_t'(hx), coord_t'(hy)};
    return r;
  endfunction

  function automatic int rnd(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 256;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic pair_t gen_pair();
    int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    int span, k, m, px, py, ox, oy;
    span = ($urandom_range(0, 2) == 0) ? 64 : (($urandom_range(0, 1) == 0) ? 1024 : 8000);
    case ($urandom_range(0, 9))
      0, 1: begin
        return pair_t'({$urandom, $urandom, $urandom, $urandom});
      end
      2, 3, 4, 5: begin
        // build B through a point taken on A, so most of these cross
        ax0 = rnd(span); ay0 = rnd(span); ax1 = rnd(span); ay1 = rnd(span);
        k   = $urandom_range(0, 8);
        px  = ax0 + (ax1 - ax0) * k / 8;
        py  = ay0 + (ay1 - ay0) * k / 8;
        bx0 = rnd(span); by0 = rnd(span);
        m   = $urandom_range(0, 8);
        bx1 = px + (px - bx0) * m / 8;
        by1 = py + (py - by0) * m / 8;
      end
      6: begin
        // shifted copy of A: zero denominator
        ax0 = rnd(8000); ay0 = rnd(8000); ax1 = rnd(8000); ay1 = rnd(8000);
        ox  = rnd(4000); oy = rnd(4000);
        bx0 = ax0 + ox; by0 = ay0 + oy; bx1 = ax1 + ox; by1 = ay1 + oy;
      end
      7: begin
        // short segments close together: denominator near the threshold
        ax0 = rnd(16000); ay0 = rnd(16000);
        ax1 = ax0 + rnd(8); ay1 = ay0 + rnd(8);
        bx0 = ax0 + rnd(16); by0 = ay0 + rnd(16);
        bx1 = bx0 + rnd(8); by1 = by0 + rnd(8);
      end
      8: begin
        ax0 = rnd(span); ay0 = rnd(span); ax1 = rnd(span); ay1 = rnd(span);
        bx1 = rnd(span); by1 = rnd(span);
        if ($urandom_range(0, 1) == 0) begin
          bx0 = ax1; by0 = ay1;
        end else begin
          bx0 = rnd(span); by0 = rnd(span); ax1 = ax0; ay1 = ay0;
        end
      end
      default: begin
        ax0 = pick_extreme(); ay0 = pick_extreme(); ax1 = pick_extreme();
        ay1 = pick_extreme(); bx0 = pick_extreme(); by0 = pick_extreme();
        bx1 = pick_extreme(); by1 = pick_extreme();
      end
    endcase
    return mk_pair(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
  endfunction

  task automatic send_pair(input pair_t p, input crossing_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      pair_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pair_ch.valid <= 1'b1;
    pair_ch.a0_x  <= p.a0_x;
    pair_ch.a0_y  <= p.a0_y;
    pair_ch.a1_x  <= p.a1_x;
    pair_ch.a1_y  <= p.a1_y;
    pair_ch.b0_x  <= p.b0_x;
    pair_ch.b0_y  <= p.b0_y;
    pair_ch.b1_x  <= p.b1_x;
    pair_ch.b1_y  <= p.b1_y;
    do @(posedge clk_i); while (!pair_ch.ready);
    crossing_q.push_back(want);
    pairs_sent++;
  endtask

  // leave the input idle until every word in flight has come back
  task automatic drain();
    pair_ch.valid <= 1'b0;
    do @(posedge clk_i); while (crossing_q.size() != 0);
  endtask

  task automatic write_threshold(input logic [TH_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thresh_model = v;
  endtask

  always @(posedge clk_i) begin : check_results
    crossing_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (crossing_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual hit %0b x %0d y %0d",
                 $time, res_ch.hit, res_ch.hit_x, res_ch.hit_y);
        crossing_errs++;
      end else begin
        want = crossing_q.pop_front();
        if (res_ch.hit !== want.hit) begin
          $display("%0t hit: expected %0b actual %0b", $time, want.hit, res_ch.hit);
          crossing_errs++;
        end
        if (res_ch.hit_x !== want.hit_x) begin
          $display("%0t hit_x: expected %0d actual %0d", $time, want.hit_x, res_ch.hit_x);
          crossing_errs++;
        end
        if (res_ch.hit_y !== want.hit_y) begin
          $display("%0t hit_y: expected %0d actual %0d", $time, want.hit_y, res_ch.hit_y);
          crossing_errs++;
        end
      end
      rx_stall = steady ? 0 : $urandom_range(0, 3);
    end
    if (rx_hold || rx_stall != 0) begin
      res_ch.ready <= 1'b0;
      if (rx_stall != 0) rx_stall--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // long hold on the result side while pairs keep coming, so the skid fills
  initial begin
    rx_hold = 1'b0;
    wait (pairs_sent >= 400);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("** segment_intersection: FAILED **");
    $finish;
  end

  initial begin
    int        ph;
    int        n_items;
    logic [TH_W-1:0] thr;
    crossing_t want;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    pair_ch.valid  = 1'b0;
    pair_ch.a0_x   = '0;
    pair_ch.a0_y   = '0;
    pair_ch.a1_x   = '0;
    pair_ch.a1_y   = '0;
    pair_ch.b0_x   = '0;
    pair_ch.b0_y   = '0;
    pair_ch.b1_x   = '0;
    pair_ch.b1_y   = '0;
    thresh_model   = segx_pkg::THRESH_RESET;
    pairs_sent     = 0;
    steady         = 1'b0;

    // 1.0 is 256 in Q8.8; small raw steps set the denominator around 66
    pair_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    pair_rows.push_back(row(0, 0, 512, 512, 0, 512, 512, 0, 1, 1, 256, 256));
    pair_rows.push_back(row(0, 0, 256, 0, 256, 0, 256, 256, 1, 1, 256, 0));
    pair_rows.push_back(row(256, 256, 512, 0, 0, 0, 256, 256, 1, 1, 256, 256));
    pair_rows.push_back(row(0, 0, 256, 0, 512, -256, 512, 256, 1, 0, 0, 0));
    pair_rows.push_back(row(0, 0, 256, 0, 257, -256, 257, 256, 1, 0, 0, 0));
    pair_rows.push_back(row(0, 0, 256, 0, 0, 256, 256, 256, 1, 0, 0, 0));
    pair_rows.push_back(row(0, 0, 512, 0, 256, 0, 768, 0, 1, 0, 0, 0));
    pair_rows.push_back(row(128, 0, 128, 0, 0, 0, 256, 0, 1, 0, 0, 0));
    pair_rows.push_back(row(0, 0, 1, 0, 0, -32, 0, 33, 1, 0, 0, 0));
    pair_rows.push_back(row(0, 0, 1, 0, 0, 32, 0, -33, 1, 0, 0, 0));
    pair_rows.push_back(row(0, 0, 1, 0, 0, -33, 0, 33, 1, 1, 0, 0));
    pair_rows.push_back(row(0, 0, 1, 0, 0, 33, 0, -33, 1, 1, 0, 0));
    pair_rows.push_back(row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            1, 0, 0, 0));
    pair_rows.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, 1, 0, 0, 0));
    pair_rows.push_back(row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                            0, 0, 0, 0));
    pair_rows.push_back(row(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767,
                            0, 0, 0, 0));
    pair_rows.push_back(row(-256, -256, 300, 100, 0, -300, -10, 200, 0, 0, 0, 0));
    pair_rows.push_back(row(-1000, -500, 1000, 700, -800, 600, 900, -400, 0, 0, 0, 0));
    pair_rows.push_back(row(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846,
                            0, 0, 0, 0));
    pair_rows.push_back(row(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845,
                            0, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs run at the reset threshold
    foreach (pair_rows[i]) begin
      want = pair_rows[i].typed ? pair_rows[i].want
                                : predict_crossing(pair_rows[i].p, thresh_model);
      send_pair(pair_rows[i].p, want);
    end
    drain();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin thr = '0;                      n_items = 250; end
        1:       begin thr = '1;                      n_items = 200; end
        2:       begin thr = TH_W'($urandom);         n_items = 200; end
        3:       begin thr = TH_W'(1);                n_items = 150; end
        default: begin thr = segx_pkg::THRESH_RESET;  n_items = 250; end
      endcase
      steady = (ph == 2);
      write_threshold(thr);
      repeat (n_items) begin
        pair_t p;
        p = gen_pair();
        send_pair(p, predict_crossing(p, thresh_model));
      end
      drain();
    end
    steady = 1'b0;

    repeat (2 * LAT) @(posedge clk_i);
    if (crossing_errs == 0) begin
      $display("** segment_intersection: PASSED **");
    end else begin
      $display("** segment_intersection: FAILED **");
    end
    $finish;
  end

endmodule
